// ===== sv/arqsw_pkg.sv =====
// Shared types, sizes and codes for the ARQ sender window.
// No dependencies; the cell, top level and checker import this package.
package arqsw_pkg;

   localparam int WINDOW_SLOTS  = 8;
   localparam int BACKLOG_DEPTH = 16;
   localparam int SLOT_W  = (WINDOW_SLOTS > 1) ? $clog2(WINDOW_SLOTS) : 1;
   localparam int BL_AW   = (BACKLOG_DEPTH > 1) ? $clog2(BACKLOG_DEPTH) : 1;
   localparam int BL_CW   = $clog2(BACKLOG_DEPTH + 1);
   localparam int TIMER_W = 17;
   localparam int PKT_W   = 40;

   localparam logic [15:0] RETRY_RESET = 16'd200;
   localparam logic        KIND_SEND   = 1'b0;
   localparam logic        KIND_DROP   = 1'b1;

   typedef enum logic [1:0] {
      OP_ADD  = 2'd0,
      OP_ACK  = 2'd1,
      OP_TICK = 2'd2
   } op_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SWEEP,
      ST_TAIL
   } state_type;

   typedef struct packed {
      logic [7:0]  tag;
      logic [15:0] number;
      logic [15:0] checksum;
   } pkt_type;

   // Broadcast to every cell for the whole sweep.
   typedef struct packed {
      logic [1:0]  op;
      pkt_type     pkt;
      logic        conf;
      logic        resend;
      logic [15:0] elapsed;
      logic [15:0] retry;
      logic        fill_avail;
      pkt_type     fill;
   } cmd_type;

   // What the visited cell reports; idle cells drive zero.
   typedef struct packed {
      logic    emit;
      logic    pop;
      pkt_type pkt;
   } cell_out_type;

   function automatic logic [2:0] slot_field(input logic [SLOT_W-1:0] idx);
      logic [SLOT_W+2:0] w;
      w = {3'b000, idx};
      return w[2:0];
   endfunction

endpackage

// ===== sv/arqsw_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module arqsw_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [0:DEPTH-1];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/arqsw_cell.sv =====
// One window slot: packet, retry timer and the visit token of the sweep.
// Depends on arqsw_pkg.
module arqsw_cell import arqsw_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         advance,
   input  logic         visit_in,
   input  logic         carry_in,
   input  cmd_type      cmd,
   output logic         visit_out,
   output logic         carry_out,
   output cell_out_type res
);

   logic               visit_ff, carry_ff, valid_ff;
   logic [TIMER_W-1:0] timer_ff;
   pkt_type            pkt_ff;

   logic               valid_in, carry_left, v_mid, match, emit, pop;
   logic [TIMER_W-1:0] timer_in, t_sat;
   logic [TIMER_W:0]   t_sum;
   pkt_type            pkt_in;

   always_comb begin
      valid_in   = valid_ff;
      timer_in   = timer_ff;
      pkt_in     = pkt_ff;
      carry_left = carry_ff;
      emit       = 1'b0;
      pop        = 1'b0;
      v_mid      = valid_ff;
      match      = valid_ff && (pkt_ff.number == cmd.pkt.number) &&
                   (pkt_ff.checksum == cmd.pkt.checksum);
      t_sum      = (TIMER_W+1)'(timer_ff) + (TIMER_W+1)'(cmd.elapsed);
      t_sat      = t_sum[TIMER_W] ? '1 : t_sum[TIMER_W-1:0];
      if (visit_ff) begin
         unique case (cmd.op)
            OP_ADD: begin
               if (carry_ff && !valid_ff) begin
                  valid_in   = 1'b1;
                  pkt_in     = cmd.pkt;
                  timer_in   = TIMER_W'(cmd.retry);
                  carry_left = 1'b0;
               end
            end
            OP_ACK: begin
               if (match) begin
                  if (cmd.conf) begin
                     v_mid = 1'b0;
                  end else if (cmd.resend) begin
                     emit = 1'b1;
                  end
               end
               valid_in = v_mid;
               // refill from the backlog head once the slot is empty
               if (cmd.fill_avail && !v_mid) begin
                  valid_in = 1'b1;
                  pkt_in   = cmd.fill;
                  timer_in = TIMER_W'(cmd.retry);
                  pop      = 1'b1;
               end
            end
            OP_TICK: begin
               if (valid_ff) begin
                  if (t_sat >= TIMER_W'(cmd.retry)) begin
                     timer_in = '0;
                     emit     = 1'b1;
                  end else begin
                     timer_in = t_sat;
                  end
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         visit_ff <= 1'b0;
         carry_ff <= 1'b0;
         valid_ff <= 1'b0;
         timer_ff <= '0;
      end else if (advance) begin
         visit_ff <= visit_in;
         carry_ff <= carry_in;
         valid_ff <= valid_in;
         timer_ff <= timer_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         pkt_ff <= pkt_in;
      end
   end

   assign visit_out = visit_ff;
   assign carry_out = visit_ff ? carry_left : 1'b0;
   assign res.emit  = emit;
   assign res.pop   = pop;
   assign res.pkt   = visit_ff ? pkt_ff : '0;

endmodule

// ===== sv/arq_sender_window.sv =====
// Top level of the ARQ sender window: sweep control, backlog FIFO, result register.
// Depends on arqsw_pkg, arqsw_cell and arqsw_ram.
//
// Selective-repeat sender window. Every transaction on the req_ channel (add,
// ack or tick) is handled by a token that walks the row of WINDOW_SLOTS slot
// cells, one cell per clock while the sweep is not halted. A transaction
// passes through accept, one visit per slot and a closing cycle, and is held
// longer while the rsp_ channel stalls: a second result halts the sweep while
// the output register is full, and the final result or a drop holds the
// closing cycle. The cell row sets these steps: each slot is visited once in
// order, which gives ack refills and tick sends their slot order. An add that
// finds no free slot is written to the backlog RAM in the closing cycle, or
// reported as a drop (kind 1, slot 0) when the backlog is full. Results of one
// transaction are held one behind so that the final one carries last = 1. A
// new transaction is taken while the last result still waits in the output
// register. retry_time is written on the csr_ channel, which is always ready;
// write it only while the block is idle. Reset is synchronous and needs no
// clearing pass.
module arq_sender_window import arqsw_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_op,
   input  logic [7:0]  req_packet_tag,
   input  logic [15:0] req_packet_number,
   input  logic [15:0] req_packet_checksum,
   input  logic        req_ack_confirmed,
   input  logic        req_ack_resend,
   input  logic [15:0] req_elapsed,
   // result channel
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_kind,
   output logic [2:0]  rsp_slot,
   output logic [7:0]  rsp_out_tag,
   output logic [15:0] rsp_out_number,
   output logic [15:0] rsp_out_checksum,
   output logic        rsp_last,
   // configuration
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [15:0] csr_retry_time
);

   typedef struct packed {
      logic       kind;
      logic [2:0] slot;
      pkt_type    pkt;
      logic       last;
   } rsp_type;

   // transaction latched at accept, stable for the sweep
   logic [1:0]  op_ff;
   pkt_type     item_ff;
   logic        conf_ff, resend_ff;
   logic [15:0] elapsed_ff;
   logic [15:0] retry_ff;

   state_type   state_ff, state_in;
   logic [SLOT_W-1:0] idx_ff, idx_in;
   logic        lcarry_ff, lcarry_in;

   // one-behind result holder, so the final one can be tagged last
   logic        pend_v_ff, pend_v_in;
   logic [2:0]  pend_slot_ff, pend_slot_in;
   pkt_type     pend_pkt_ff, pend_pkt_in;

   // backlog FIFO pointers
   logic [BL_AW-1:0] head_ff, head_in, head_next, tail;
   logic [BL_CW-1:0] count_ff, count_in;
   logic [BL_CW:0]   tail_sum;

   logic        rsp_valid_ff;
   rsp_type     rsp_ff, out_data;
   logic        out_ld, out_free;

   logic        launch, advance, ram_we, drop, push;
   cmd_type     cmd;
   pkt_type     ram_rd;
   cell_out_type hit;
   cell_out_type cell_res [0:WINDOW_SLOTS-1];
   logic        visit_chain [0:WINDOW_SLOTS];
   logic        carry_chain [0:WINDOW_SLOTS];

   assign req_ready = (state_ff == ST_IDLE);
   assign csr_ready = 1'b1;
   assign launch    = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   // ---- broadcast command ----
   always_comb begin
      cmd.op         = op_ff;
      cmd.pkt        = item_ff;
      cmd.conf       = conf_ff;
      cmd.resend     = resend_ff;
      cmd.elapsed    = elapsed_ff;
      cmd.retry      = retry_ff;
      cmd.fill_avail = (count_ff != '0);
      cmd.fill       = ram_rd;
   end

   // ---- cell row: token enters at slot 0 on accept ----
   assign visit_chain[0] = launch;
   assign carry_chain[0] = launch && (req_op == OP_ADD);

   for (genvar i = 0; i < WINDOW_SLOTS; i++) begin : g_cell
      arqsw_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .visit_in  (visit_chain[i]),
         .carry_in  (carry_chain[i]),
         .cmd       (cmd),
         .visit_out (visit_chain[i+1]),
         .carry_out (carry_chain[i+1]),
         .res       (cell_res[i])
      );
   end

   // only the visited cell drives nonzero
   always_comb begin
      hit = '0;
      for (int i = 0; i < WINDOW_SLOTS; i++) begin
         hit = cell_out_type'(hit | cell_res[i]);
      end
   end

   // sweep halts only when a second result meets a full output register
   assign advance = !((state_ff == ST_SWEEP) && hit.emit && pend_v_ff && !out_free);

   // ---- backlog addressing ----
   assign head_next = (head_ff == BL_AW'(BACKLOG_DEPTH - 1)) ? '0 : head_ff + BL_AW'(1);

   always_comb begin
      tail_sum = (BL_CW+1)'(head_ff) + (BL_CW+1)'(count_ff);
      if (tail_sum >= (BL_CW+1)'(BACKLOG_DEPTH)) begin
         tail_sum = tail_sum - (BL_CW+1)'(BACKLOG_DEPTH);
      end
      tail = tail_sum[BL_AW-1:0];
   end

   assign drop = (op_ff == OP_ADD) && lcarry_ff && (count_ff == BL_CW'(BACKLOG_DEPTH));
   assign push = (op_ff == OP_ADD) && lcarry_ff && (count_ff != BL_CW'(BACKLOG_DEPTH));

   // ---- control ----
   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      lcarry_in    = lcarry_ff;
      pend_v_in    = pend_v_ff;
      pend_slot_in = pend_slot_ff;
      pend_pkt_in  = pend_pkt_ff;
      head_in      = head_ff;
      count_in     = count_ff;
      out_ld       = 1'b0;
      out_data     = '0;
      ram_we       = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (launch) begin
               state_in  = ST_SWEEP;
               idx_in    = '0;
               pend_v_in = 1'b0;
            end
         end
         ST_SWEEP: begin
            if (advance) begin
               if (hit.emit) begin
                  if (pend_v_ff) begin
                     out_ld   = 1'b1;
                     out_data = '{kind: KIND_SEND, slot: pend_slot_ff,
                                  pkt: pend_pkt_ff, last: 1'b0};
                  end
                  pend_v_in    = 1'b1;
                  pend_slot_in = slot_field(idx_ff);
                  pend_pkt_in  = hit.pkt;
               end
               if (hit.pop) begin
                  head_in  = head_next;
                  count_in = count_ff - BL_CW'(1);
               end
               if (idx_ff == SLOT_W'(WINDOW_SLOTS - 1)) begin
                  state_in  = ST_TAIL;
                  lcarry_in = carry_chain[WINDOW_SLOTS];
               end else begin
                  idx_in = idx_ff + SLOT_W'(1);
               end
            end
         end
         ST_TAIL: begin
            priority if (pend_v_ff) begin
               if (out_free) begin
                  out_ld    = 1'b1;
                  out_data  = '{kind: KIND_SEND, slot: pend_slot_ff,
                                pkt: pend_pkt_ff, last: 1'b1};
                  pend_v_in = 1'b0;
                  state_in  = ST_IDLE;
               end
            end else if (drop) begin
               if (out_free) begin
                  out_ld   = 1'b1;
                  out_data = '{kind: KIND_DROP, slot: 3'd0, pkt: item_ff, last: 1'b1};
                  state_in = ST_IDLE;
               end
            end else begin
               if (push) begin
                  ram_we   = 1'b1;
                  count_in = count_ff + BL_CW'(1);
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         idx_ff       <= '0;
         lcarry_ff    <= 1'b0;
         pend_v_ff    <= 1'b0;
         head_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         retry_ff     <= RETRY_RESET;
      end else begin
         state_ff  <= state_in;
         idx_ff    <= idx_in;
         lcarry_ff <= lcarry_in;
         pend_v_ff <= pend_v_in;
         head_ff   <= head_in;
         count_ff  <= count_in;
         if (out_ld) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (csr_valid) begin
            retry_ff <= csr_retry_time;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      pend_slot_ff <= pend_slot_in;
      pend_pkt_ff  <= pend_pkt_in;
      if (launch) begin
         op_ff      <= req_op;
         item_ff    <= '{tag: req_packet_tag, number: req_packet_number,
                         checksum: req_packet_checksum};
         conf_ff    <= req_ack_confirmed;
         resend_ff  <= req_ack_resend;
         elapsed_ff <= req_elapsed;
      end
      if (out_ld) begin
         rsp_ff <= out_data;
      end
   end

   // backlog RAM; read address follows the head so the head entry is ready
   arqsw_ram #(
      .WIDTH (PKT_W),
      .DEPTH (BACKLOG_DEPTH)
   ) u_backlog (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (tail),
      .wr_data (item_ff),
      .rd_addr (head_in),
      .rd_data (ram_rd)
   );

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_kind         = rsp_ff.kind;
   assign rsp_slot         = rsp_ff.slot;
   assign rsp_out_tag      = rsp_ff.pkt.tag;
   assign rsp_out_number   = rsp_ff.pkt.number;
   assign rsp_out_checksum = rsp_ff.pkt.checksum;
   assign rsp_last         = rsp_ff.last;

endmodule

// ===== sv/arqsw_checker.sv =====
// Port-level checks for the ARQ sender window, bound to the top level.
// Depends on arqsw_pkg and arq_sender_window.
module arqsw_checker import arqsw_pkg::*; (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic        rsp_kind,
   input logic [2:0]  rsp_slot,
   input logic [7:0]  rsp_out_tag,
   input logic [15:0] rsp_out_number,
   input logic        rsp_last
);

   // a stalled result stays
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_out_tag) &&
                                     $stable(rsp_out_number)))
      else $error("rsp changed while stalled");

   // one transaction at a time: the sweep keeps the request side closed
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request accepted during a sweep");

   // a drop is the only result of its add
   a_drop_form: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_kind == KIND_DROP) |-> (rsp_last && rsp_slot == 3'd0))
      else $error("drop result not last or slot nonzero");

   // a sweep through every slot keeps the request side closed past its start
   a_no_quick_reopen: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> ##1 !req_ready)
      else $error("request side reopened too early");

endmodule

bind arq_sender_window arqsw_checker u_arqsw_checker (.*);
